/* rtl/msfp_pkg.sv */
// msfp_pkg: widths, frame byte positions and shared types for the motor status frame parser
// no dependencies; imported by the channel interfaces and the parser top level
`timescale 1ns / 1ps

package msfp_pkg;

  // frame layout
  localparam int MAX_FRAME_BYTES = 32;
  localparam int POS_WIDTH       = 6;
  localparam logic [POS_WIDTH-1:0] FRAME_MAX   = POS_WIDTH'(MAX_FRAME_BYTES);
  localparam logic [POS_WIDTH-1:0] ENC_FIRST   = POS_WIDTH'(3);
  localparam logic [POS_WIDTH-1:0] ENC_LAST    = POS_WIDTH'(18);
  localparam logic [POS_WIDTH-1:0] LEVEL_POS   = POS_WIDTH'(19);
  localparam logic [POS_WIDTH-1:0] VOLT_HI_POS = POS_WIDTH'(20);
  localparam logic [POS_WIDTH-1:0] VOLT_LO_POS = POS_WIDTH'(21);

  // field widths
  localparam int BYTE_WIDTH  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int NUM_COUNTS  = 4;
  localparam int VOLT_WIDTH  = 16;
  localparam int MV_WIDTH    = 23;

  // raw voltage units to millivolts
  localparam logic [6:0] MV_PER_UNIT = 7'd100;

  typedef logic [BYTE_WIDTH-1:0]         byte_t;
  typedef logic [POS_WIDTH-1:0]          pos_t;
  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef count_t                        count_array_t [NUM_COUNTS];
  typedef logic [VOLT_WIDTH-1:0]         volt_t;
  typedef logic [MV_WIDTH-1:0]           mv_t;

endpackage

/* rtl/msfp_stream_if.sv */
// msfp_stream_if: valid/ready channels for received frame bytes and parsed status results
// depends on msfp_pkg for the field types
`timescale 1ns / 1ps

// byte channel into the parser
interface msfp_in_if;
  import msfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// status result channel out of the parser
interface msfp_out_if;
  import msfp_pkg::*;

  logic   valid;
  logic   ready;
  logic   frame_ok;
  count_t left_front_count;
  count_t right_front_count;
  count_t left_rear_count;
  count_t right_rear_count;
  byte_t  battery_percent;
  mv_t    battery_millivolts;

  modport source (output valid, output frame_ok, output left_front_count,
                  output right_front_count, output left_rear_count,
                  output right_rear_count, output battery_percent,
                  output battery_millivolts, input ready);
  modport sink   (input valid, input frame_ok, input left_front_count,
                  input right_front_count, input left_rear_count,
                  input right_rear_count, input battery_percent,
                  input battery_millivolts, output ready);
endinterface

/* rtl/motor_status_frame_parser_unit.sv */
// motor_status_frame_parser_unit: byte-wise status frame parser with checksum verdict
// depends on msfp_pkg and the channel interfaces in msfp_stream_if.sv
//
//   channel  | dir | payload                                          | request
//   ---------+-----+--------------------------------------------------+----------------------
//   rx       | in  | rx_byte, end_of_frame                            | one frame byte
//   status   | out | frame_ok, four encoder counts, battery_percent,  | one parsed frame,
//            |     | battery_millivolts                               | on the final byte
//
// one byte is taken every cycle while rx.ready is high; the result of a final
// byte appears in the output register on the next cycle, set by the byte
// capture, the x100 multiply and the checksum compare feeding that register.
// rx.ready drops only while a result sits unread in the output register.
// rst (synchronous, active high) clears byte position, sum, captured fields
// and the output valid flag.
`timescale 1ns / 1ps

module motor_status_frame_parser_unit (
  input logic      clk,
  input logic      rst,
  msfp_in_if.sink  rx,
  msfp_out_if.source status
);
  import msfp_pkg::*;

  // frame state
  pos_t         pos;
  byte_t        sum;
  count_array_t counts;
  byte_t        level;
  volt_t        volt;

  pos_t         pos_next;
  byte_t        sum_next;
  count_array_t counts_next;
  byte_t        level_next;
  volt_t        volt_next;
  mv_t          mv_next;

  logic         rx_acc;
  logic [POS_WIDTH-1:0] enc_diff;
  logic [3:0]   enc_off;
  logic [1:0]   enc_lane;

  // input side moves whenever the output register is free or being drained
  assign rx.ready = !status.valid || status.ready;
  assign rx_acc   = rx.valid && rx.ready;

  // byte lane selection for the encoder counts
  assign enc_diff = pos - ENC_FIRST;
  assign enc_off  = enc_diff[3:0];
  assign enc_lane = ~enc_off[1:0];

  // capture of the current byte into its field lane
  always_comb begin
    counts_next = counts;
    level_next  = level;
    volt_next   = volt;
    case (pos) inside
      [ENC_FIRST:ENC_LAST]: begin
        counts_next[enc_off[3:2]][{enc_lane, 3'b000} +: BYTE_WIDTH] = rx.rx_byte;
      end
      LEVEL_POS: begin
        level_next = rx.rx_byte;
      end
      VOLT_HI_POS: begin
        volt_next[VOLT_WIDTH-1 -: BYTE_WIDTH] = rx.rx_byte;
      end
      VOLT_LO_POS: begin
        volt_next[BYTE_WIDTH-1:0] = rx.rx_byte;
      end
      default: begin
      end
    endcase
  end

  // position and running sum; both restart after the final byte
  always_comb begin
    if (rx.end_of_frame) begin
      pos_next = '0;
      sum_next = '0;
    end else begin
      sum_next = sum + rx.rx_byte;
      pos_next = (pos < FRAME_MAX) ? pos + POS_WIDTH'(1) : FRAME_MAX;
    end
  end

  // raw voltage to millivolts
  assign mv_next = MV_WIDTH'(volt_next) * MV_WIDTH'(MV_PER_UNIT);

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      sum   <= '0;
      level <= '0;
      volt  <= '0;
      for (int i = 0; i < NUM_COUNTS; i++) begin
        counts[i] <= '0;
      end
    end else if (rx_acc) begin
      pos    <= pos_next;
      sum    <= sum_next;
      counts <= counts_next;
      level  <= level_next;
      volt   <= volt_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (rx_acc && rx.end_of_frame) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  // output payload, loaded on the final byte
  always_ff @(posedge clk) begin
    if (rx_acc && rx.end_of_frame) begin
      status.frame_ok           <= (sum == rx.rx_byte);
      status.left_front_count   <= counts_next[0];
      status.right_front_count  <= counts_next[1];
      status.left_rear_count    <= counts_next[2];
      status.right_rear_count   <= counts_next[3];
      status.battery_percent    <= level_next;
      status.battery_millivolts <= mv_next;
    end
  end

  // position never runs past the frame maximum
  a_pos_bound: assert property (@(posedge clk) disable iff (rst) pos <= FRAME_MAX)
    else $error("byte position beyond frame maximum");

  // a final byte restarts the frame
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    rx_acc && rx.end_of_frame |=> pos == '0 && sum == '0)
    else $error("frame state not cleared after final byte");

  // a new result only follows an accepted final byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(status.valid) |-> $past(rx_acc && rx.end_of_frame))
    else $error("result without a final byte");

  // a pending result that is not taken blocks further bytes
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    status.valid && !status.ready |-> !rx_acc)
    else $error("byte accepted while result stalled");

endmodule
